FILE: rtl/mecanum_velocity_to_motor_drive_defines.svh
// ----------------------------------------------------------------------------
// Mecanum drive assertion macros
// Shared concurrent assertion wrappers for the mecanum drive RTL.
// ----------------------------------------------------------------------------
`ifndef MECANUM_VELOCITY_TO_MOTOR_DRIVE_DEFINES_SVH
`define MECANUM_VELOCITY_TO_MOTOR_DRIVE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define MVMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MVMD_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/mvmd_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum drive package
// Widths, word types, register indexes and wheel constants.
// ----------------------------------------------------------------------------
package mvmd_pkg;

  localparam int unsigned SpeedW    = 24;  // Q8.16 body velocity
  localparam int unsigned GeomW     = 16;  // Q0.16 geometry sum
  localparam int unsigned GainW     = 24;  // Q0.24 wheel gain
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = SpeedW + GeomW;  // turn product
  localparam int unsigned WheelW    = SpeedW + 2;      // sum of three terms
  localparam int unsigned MagW      = WheelW - 1;      // |wheel| fits unsigned
  localparam int unsigned CntW      = MagW;            // (mag * gain) >> 24
  localparam int unsigned DutyW     = 15;
  localparam int unsigned DutyLimit = 16800;
  localparam int unsigned NumWheels = 4;
  localparam int unsigned CfgIdxW   = 3;

  // Wheel lanes: 0 front left, 1 front right, 2 rear left, 3 rear right.
  localparam logic [NumWheels-1:0] WheelSideNeg = 4'b1001;  // subtract sideways
  localparam logic [NumWheels-1:0] WheelTurnNeg = 4'b0101;  // subtract turn term
  localparam logic [NumWheels-1:0] WheelRight   = 4'b1010;  // inverted polarity

  typedef enum logic [CfgIdxW-1:0] {
    CfgGeometrySum   = 3'd0,
    CfgGainFrontLeft = 3'd1,
    CfgGainFrontRight = 3'd2,
    CfgGainRearLeft  = 3'd3,
    CfgGainRearRight = 3'd4
  } cfg_idx_e;

  typedef logic signed [WheelW-1:0] wheel_t;

  typedef struct packed {
    logic [GeomW-1:0]                  geometry_sum;
    logic [NumWheels-1:0][GainW-1:0]   gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] forward_speed;
    logic signed [SpeedW-1:0] sideways_speed;
    logic signed [SpeedW-1:0] turn_rate;
  } in_t;

  typedef struct packed {
    logic [DutyW-1:0] front_left_duty;
    logic [DutyW-1:0] front_right_duty;
    logic [DutyW-1:0] rear_left_duty;
    logic [DutyW-1:0] rear_right_duty;
    logic             front_left_in1;
    logic             front_left_in2;
    logic             front_right_in1;
    logic             front_right_in2;
    logic             rear_left_in1;
    logic             rear_left_in2;
    logic             rear_right_in1;
    logic             rear_right_in2;
  } out_t;

endpackage

FILE: rtl/mvmd_cfg.sv
// ----------------------------------------------------------------------------
// Mecanum drive configuration registers
// Decodes register writes into geometry and per-wheel gain registers.
// ----------------------------------------------------------------------------
module mvmd_cfg import mvmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [GainW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgGeometrySum:    cfg_d.geometry_sum = cfg_data_i[GeomW-1:0];
        CfgGainFrontLeft:  cfg_d.gain[0]      = cfg_data_i;
        CfgGainFrontRight: cfg_d.gain[1]      = cfg_data_i;
        CfgGainRearLeft:   cfg_d.gain[2]      = cfg_data_i;
        CfgGainRearRight:  cfg_d.gain[3]      = cfg_data_i;
        default:           cfg_d = cfg_q;  // drop writes past the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/mvmd_kin.sv
// ----------------------------------------------------------------------------
// Mecanum drive kinematics stages
// Three stages: turn product, truncation toward zero, per-wheel sums.
// ----------------------------------------------------------------------------
module mvmd_kin import mvmd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output wheel_t wheel_o [NumWheels]
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [SpeedW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [ProdW-1:0]  p1_q, p1_d;
  logic signed [SpeedW-1:0] t2_q, t2_d;
  wheel_t                   w3_q [NumWheels];
  wheel_t                   w3_d [NumWheels];

  logic signed [ProdW:0]    prod_full;
  logic signed [ProdW-1:0]  biased;
  wheel_t                   xs, ys, ts;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: geometry times turn rate.
  always_comb begin
    prod_full = $signed({1'b0, cfg_i.geometry_sum}) * $signed(in_i.turn_rate);
    p1_d      = prod_full[ProdW-1:0];
  end

  // Stage 2: bias negative products so the arithmetic shift rounds toward zero.
  always_comb begin
    biased = p1_q + (p1_q[ProdW-1] ? {{(ProdW-FracW){1'b0}}, {FracW{1'b1}}} : '0);
    t2_d   = biased[ProdW-1:FracW];
  end

  // Stage 3: x +/- y +/- t per wheel.
  always_comb begin
    xs = WheelW'(x2_q);
    ys = WheelW'(y2_q);
    ts = WheelW'(t2_q);
    for (int k = 0; k < NumWheels; k++) begin
      w3_d[k] = xs + (WheelSideNeg[k] ? -ys : ys) + (WheelTurnNeg[k] ? -ts : ts);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p1_q <= p1_d;
      x1_q <= in_i.forward_speed;
      y1_q <= in_i.sideways_speed;
    end
    if (rdy2 && v1_q) begin
      t2_q <= t2_d;
      x2_q <= x1_q;
      y2_q <= y1_q;
    end
    if (rdy3 && v2_q) begin
      w3_q <= w3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign wheel_o     = w3_q;

endmodule

FILE: rtl/mvmd_drive.sv
// ----------------------------------------------------------------------------
// Mecanum drive wheel output stages
// Four lanes: magnitude, gain product, saturation and bridge direction bits.
// ----------------------------------------------------------------------------
`include "mecanum_velocity_to_motor_drive_defines.svh"

module mvmd_drive import mvmd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  wheel_t wheel_i [NumWheels],
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output out_t   out_o
);

  logic v4_q, v5_q, v6_q;
  logic rdy4, rdy5, rdy6;

  logic [MagW-1:0] mag4_q  [NumWheels];
  logic [MagW-1:0] mag4_d  [NumWheels];
  logic            neg4_q  [NumWheels];
  logic [CntW-1:0] cnt5_q  [NumWheels];
  logic [CntW-1:0] cnt5_d  [NumWheels];
  logic            neg5_q  [NumWheels];
  out_t            out_q, out_d;

  logic [WheelW-1:0]     abs_full [NumWheels];
  logic [MagW+GainW-1:0] prod     [NumWheels];
  logic [DutyW-1:0]      duty     [NumWheels];
  logic                  fwd      [NumWheels];
  logic                  rev      [NumWheels];
  logic                  in1      [NumWheels];
  logic                  in2      [NumWheels];
  logic [CntW-1:0]       sat;

  assign rdy6       = !v6_q || out_ready_i;
  assign rdy5       = !v5_q || rdy6;
  assign rdy4       = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  always_comb begin
    for (int k = 0; k < NumWheels; k++) begin
      abs_full[k] = wheel_i[k][WheelW-1] ? -wheel_i[k] : wheel_i[k];
      mag4_d[k]   = abs_full[k][MagW-1:0];
      prod[k]     = (MagW+GainW)'(mag4_q[k]) * (MagW+GainW)'(cfg_i.gain[k]);
      cnt5_d[k]   = prod[k][MagW+GainW-1:GainW];
    end
  end

  // Clamp, then steer the bridge; a zero count drives both inputs low.
  always_comb begin
    sat = '0;
    for (int k = 0; k < NumWheels; k++) begin
      sat     = (cnt5_q[k] > CntW'(DutyLimit)) ? CntW'(DutyLimit) : cnt5_q[k];
      duty[k] = sat[DutyW-1:0];
      fwd[k]  = (cnt5_q[k] != '0) && !neg5_q[k];
      rev[k]  = (cnt5_q[k] != '0) && neg5_q[k];
      in1[k]  = WheelRight[k] ? rev[k] : fwd[k];
      in2[k]  = WheelRight[k] ? fwd[k] : rev[k];
    end
    out_d.front_left_duty  = duty[0];
    out_d.front_right_duty = duty[1];
    out_d.rear_left_duty   = duty[2];
    out_d.rear_right_duty  = duty[3];
    out_d.front_left_in1   = in1[0];
    out_d.front_left_in2   = in2[0];
    out_d.front_right_in1  = in1[1];
    out_d.front_right_in2  = in2[1];
    out_d.rear_left_in1    = in1[2];
    out_d.rear_left_in2    = in2[2];
    out_d.rear_right_in1   = in1[3];
    out_d.rear_right_in2   = in2[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      mag4_q <= mag4_d;
      for (int k = 0; k < NumWheels; k++) begin
        neg4_q[k] <= wheel_i[k][WheelW-1];
      end
    end
    if (rdy5 && v4_q) begin
      cnt5_q <= cnt5_d;
      neg5_q <= neg4_q;
    end
    if (rdy6 && v5_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_o       = out_q;

  `MVMD_ASSERT_NORST(a_rst_empty, !rst_ni |=> !out_valid_o, "output valid during reset")
  `MVMD_ASSERT(a_fl_dir_excl, out_valid_o |-> !(out_o.front_left_in1 && out_o.front_left_in2), "front left bridge inputs both high")
  `MVMD_ASSERT(a_fr_duty_lim, out_valid_o |-> (out_o.front_right_duty <= DutyW'(DutyLimit)), "front right duty above limit")
  `MVMD_ASSERT(a_rl_zero_off, out_valid_o && (out_o.rear_left_duty == '0) |-> !out_o.rear_left_in1 && !out_o.rear_left_in2, "rear left driven at zero duty")

endmodule

FILE: rtl/mecanum_velocity_to_motor_drive.sv
// Throughput: one word per cycle unless the output stalls, through six register stages
// (turn product, truncation, wheel sums, magnitude, gain product, saturation); the
// 25 x 24 gain multiply sets depth. A stalled output holds the pipeline in place;
// bubbles ahead of a stall still fill. Reset clears all stage valid bits and sets the
// geometry and gain registers to zero.
// ----------------------------------------------------------------------------
// Mecanum velocity to motor drive
// Four-wheel mecanum inverse kinematics with per-wheel gain, saturation and
// H-bridge direction outputs.
// ----------------------------------------------------------------------------
module mecanum_velocity_to_motor_drive import mvmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [GainW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  cfg_t   cfg;
  logic   kin_valid;
  logic   kin_ready;
  wheel_t wheel [NumWheels];

  mvmd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mvmd_kin u_kin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_data_i),
    .out_valid_o (kin_valid),
    .out_ready_i (kin_ready),
    .wheel_o     (wheel)
  );

  mvmd_drive u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (kin_valid),
    .in_ready_o  (kin_ready),
    .wheel_i     (wheel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

FILE: tb/sv/mecanum_velocity_to_motor_drive_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum velocity to motor drive testbench
// Drives body velocity commands through random gaps and output stalls, after
// a short table of corner cases, under several geometry and gain settings.
// Drive words are checked field by field: local kinematics model, or fixed table rows.
// ----------------------------------------------------------------------------
module mecanum_velocity_to_motor_drive_tb;
  import mvmd_pkg::*;

  localparam int unsigned NumRegs    = 5;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseWords = 128;
  localparam int unsigned NumVectors = 22;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned MaxReports = 40;
  localparam int unsigned GainShift  = 24;

  localparam logic signed [SpeedW-1:0] SpeedMax = 24'sh7FFFFF;
  localparam logic signed [SpeedW-1:0] SpeedMin = 24'sh800000;
  localparam logic [GeomW-1:0]         GeomMax  = '1;
  localparam logic [GainW-1:0]         GainMax  = '1;
  localparam logic [GainW-1:0]         GainEdge = 24'd33602;  // full speed lands near limit
  localparam logic [DutyW-1:0]         DutySat  = DutyW'(DutyLimit);
  localparam logic [DutyW-1:0]         DutyOff  = '0;
  // Bridge bits in word order: fl in1/in2, fr in1/in2, rl in1/in2, rr in1/in2.
  localparam logic [7:0]               DirFwd   = 8'h99;
  localparam logic [7:0]               DirRev   = 8'h66;
  localparam logic [7:0]               DirOff   = 8'h00;

  typedef struct packed {
    logic [GeomW-1:0]         geom;
    logic [GainW-1:0]         gain;
    logic signed [SpeedW-1:0] x;
    logic signed [SpeedW-1:0] y;
    logic signed [SpeedW-1:0] z;
    logic                     fixed_exp;
    logic [DutyW-1:0]         duty;
    logic [7:0]               dir;
  } vector_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             pos;
    logic             neg;
  } wheel_drive_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [GainW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  logic [GeomW-1:0] geom_sum = '0;
  logic [GainW-1:0] gain_fl = '0;
  logic [GainW-1:0] gain_fr = '0;
  logic [GainW-1:0] gain_rl = '0;
  logic [GainW-1:0] gain_rr = '0;

  out_t pending_drive_q[$];
  vector_t vectors [NumVectors];
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  mecanum_velocity_to_motor_drive dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic wheel_drive_t wheel_drive(input longint speed,
                                               input logic [GainW-1:0] gain);
    wheel_drive_t r;
    longint mag;
    longint cnt;
    mag = (speed < 0) ? -speed : speed;
    cnt = (mag * longint'(gain)) >>> GainShift;
    if (cnt > longint'(DutyLimit)) cnt = longint'(DutyLimit);
    r.duty = cnt[DutyW-1:0];
    r.pos  = (cnt != 0) && (speed > 0);
    r.neg  = (cnt != 0) && (speed < 0);
    return r;
  endfunction

  function automatic out_t predict_drive(input in_t cmd);
    out_t res;
    longint x;
    longint y;
    longint z;
    longint turn;
    wheel_drive_t fl;
    wheel_drive_t fr;
    wheel_drive_t rl;
    wheel_drive_t rr;
    x = longint'(cmd.forward_speed);
    y = longint'(cmd.sideways_speed);
    z = longint'(cmd.turn_rate);
    // Integer division truncates toward zero, as the turn term requires.
    turn = (longint'(geom_sum) * z) / (longint'(1) << FracW);
    fl = wheel_drive(x - y - turn, gain_fl);
    fr = wheel_drive(x + y + turn, gain_fr);
    rl = wheel_drive(x + y - turn, gain_rl);
    rr = wheel_drive(x - y + turn, gain_rr);
    res.front_left_duty  = fl.duty;
    res.front_right_duty = fr.duty;
    res.rear_left_duty   = rl.duty;
    res.rear_right_duty  = rr.duty;
    res.front_left_in1   = fl.pos;
    res.front_left_in2   = fl.neg;
    res.front_right_in1  = fr.neg;  // right side runs inverted
    res.front_right_in2  = fr.pos;
    res.rear_left_in1    = rl.pos;
    res.rear_left_in2    = rl.neg;
    res.rear_right_in1   = rr.neg;
    res.rear_right_in2   = rr.pos;
    return res;
  endfunction

  function automatic logic signed [SpeedW-1:0] rand_speed();
    logic signed [SpeedW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = SpeedMax;
          1: v = SpeedMin;
          2: v = '0;
          3: v = 24'sd1;
          default: v = -24'sd1;
        endcase
      end
      1, 2, 3: v = SpeedW'($urandom());
      default: begin
        v = SpeedW'($urandom_range(0, 1 << 18));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [GainW-1:0] pick_gain(input int p);
    if (p == 0) return GainMax;
    if (p == 1) return '0;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return GainMax;
      2: return GainW'($urandom());
      default: return GainW'($urandom_range(1, 70000));
    endcase
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGeometrySum:    geom_sum = value[GeomW-1:0];
      CfgGainFrontLeft:  gain_fl = value;
      CfgGainFrontRight: gain_fr = value;
      CfgGainRearLeft:   gain_rl = value;
      CfgGainRearRight:  gain_rr = value;
      default: ;  // unmapped index: drop
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_unmapped_reg();
    write_reg(CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1)), GainW'($urandom()));
  endtask

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_velocity(input in_t cmd, input out_t drive);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < in_gap_pct) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = cmd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_drive_q.push_back(drive);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < out_stall_pct) stall_left <= $urandom_range(1, 19);
    end
  end

  always @(posedge clk_i) begin : drive_monitor
    out_t expv;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drive_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: drive word expected none, got %h", $time, out_data_o);
      end else begin
        expv = pending_drive_q.pop_front();
        check_field("front_left_duty", expv.front_left_duty, out_data_o.front_left_duty);
        check_field("front_right_duty", expv.front_right_duty, out_data_o.front_right_duty);
        check_field("rear_left_duty", expv.rear_left_duty, out_data_o.rear_left_duty);
        check_field("rear_right_duty", expv.rear_right_duty, out_data_o.rear_right_duty);
        check_field("front_left_in1", expv.front_left_in1, out_data_o.front_left_in1);
        check_field("front_left_in2", expv.front_left_in2, out_data_o.front_left_in2);
        check_field("front_right_in1", expv.front_right_in1, out_data_o.front_right_in1);
        check_field("front_right_in2", expv.front_right_in2, out_data_o.front_right_in2);
        check_field("rear_left_in1", expv.rear_left_in1, out_data_o.rear_left_in1);
        check_field("rear_left_in2", expv.rear_left_in2, out_data_o.rear_left_in2);
        check_field("rear_right_in1", expv.rear_right_in1, out_data_o.rear_right_in1);
        check_field("rear_right_in2", expv.rear_right_in2, out_data_o.rear_right_in2);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    in_t cmd;
    out_t drive;
    vector_t row;
    logic [GainW-1:0] geom_word;

    vectors = '{
      // reset settings: every gain is zero
      '{'0, '0, SpeedMax, SpeedMax, SpeedMax, 1'b1, DutyOff, DirOff},
      '{'0, '0, SpeedMin, SpeedMin, SpeedMin, 1'b1, DutyOff, DirOff},
      // full gains: saturation both ways, counts that truncate to zero, and mixed extremes
      '{GeomMax, GainMax, SpeedMax, 24'sd0, 24'sd0, 1'b1, DutySat, DirFwd},
      '{GeomMax, GainMax, SpeedMin, 24'sd0, 24'sd0, 1'b1, DutySat, DirRev},
      '{GeomMax, GainMax, 24'sd0, 24'sd0, 24'sd0, 1'b1, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd1, 24'sd0, 24'sd0, 1'b1, DutyOff, DirOff},
      '{GeomMax, GainMax, -24'sd1, 24'sd0, 24'sd0, 1'b1, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, 24'sd0, -24'sd1, 1'b1, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, 24'sd0, 24'sd1, 1'b1, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, SpeedMax, 24'sd0, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, SpeedMin, 24'sd0, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, 24'sd0, SpeedMax, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, 24'sd0, 24'sd0, SpeedMin, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, SpeedMax, SpeedMax, SpeedMax, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, SpeedMin, SpeedMin, SpeedMin, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, SpeedMax, SpeedMin, SpeedMin, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainMax, SpeedMin, SpeedMax, SpeedMax, 1'b0, DutyOff, DirOff},
      // zero geometry removes the turn term
      '{'0, GainMax, 24'sd0, 24'sd0, SpeedMax, 1'b1, DutyOff, DirOff},
      '{'0, GainMax, SpeedMax, SpeedMax, 24'sd0, 1'b0, DutyOff, DirOff},
      // gain that puts full speed right at the limit, and one count past it
      '{GeomMax, GainEdge, SpeedMax, 24'sd0, 24'sd0, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainEdge, SpeedMin, 24'sd0, 24'sd0, 1'b0, DutyOff, DirOff},
      '{GeomMax, GainEdge, 24'sd65536, -24'sd32768, 24'sd100000, 1'b0, DutyOff, DirOff}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    in_gap_pct    = 20;
    out_stall_pct = 20;
    for (int i = 0; i < NumVectors; i++) begin
      row = vectors[i];
      if (row.geom != geom_sum || row.gain != gain_fl || row.gain != gain_fr ||
          row.gain != gain_rl || row.gain != gain_rr) begin
        wait_drained();
        write_reg(CfgGeometrySum, GainW'(row.geom));
        write_reg(CfgGainFrontLeft, row.gain);
        write_reg(CfgGainFrontRight, row.gain);
        write_reg(CfgGainRearLeft, row.gain);
        write_reg(CfgGainRearRight, row.gain);
        write_unmapped_reg();
      end
      cmd.forward_speed  = row.x;
      cmd.sideways_speed = row.y;
      cmd.turn_rate      = row.z;
      if (row.fixed_exp) drive = out_t'({row.duty, row.duty, row.duty, row.duty, row.dir});
      else drive = predict_drive(cmd);
      send_velocity(cmd, drive);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      // Upper data bits ride along on the geometry write and must be dropped.
      geom_word = GainW'($urandom());
      case (p % 3)
        0: geom_word[GeomW-1:0] = '0;
        1: geom_word[GeomW-1:0] = GeomMax;
        default: ;
      endcase
      write_reg(CfgGeometrySum, geom_word);
      write_reg(CfgGainFrontLeft, pick_gain(p));
      write_reg(CfgGainFrontRight, pick_gain(p));
      write_reg(CfgGainRearLeft, pick_gain(p));
      write_reg(CfgGainRearRight, pick_gain(p));
      write_unmapped_reg();
      if (p == NumPhases - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = pick_idle_pct();
        out_stall_pct = pick_idle_pct();
      end
      for (int n = 0; n < PhaseWords; n++) begin
        cmd.forward_speed  = rand_speed();
        cmd.sideways_speed = rand_speed();
        cmd.turn_rate      = rand_speed();
        send_velocity(cmd, predict_drive(cmd));
      end
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mvmd_pkg.sv
rtl/mvmd_cfg.sv
rtl/mvmd_kin.sv
rtl/mvmd_drive.sv
rtl/mecanum_velocity_to_motor_drive.sv
tb/sv/mecanum_velocity_to_motor_drive_tb.sv
